/* rtl/sorted_id_index_table_insert_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted id index table
// Implication checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_INDEX_TABLE_INSERT_TOP_ASSERT_SVH
`define SORTED_ID_INDEX_TABLE_INSERT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SITI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted id table check failed");
`define SITI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted id table check failed");
`else
`define SITI_ASSERT_SAME(label, clk, rst, ante, cons)
`define SITI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/siti_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted id index table package
// Shared types and constants for the table cells, gather logic and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package siti_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_SKIPPED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_READ_OOR  = 3'd5
  } status_e;

  typedef struct packed {
    logic [31:0] id;
    logic [30:0] size;
    logic [31:0] flag_word;
    logic [31:0] offset;
  } entry_t;

  // Per-cell compare results captured when an item is accepted.
  typedef struct packed {
    logic ge;   // cell is at or past the insert point
    logic eq;   // cell holds the searched id
    logic sel;  // cell is the one addressed by a read
  } cell_flags_t;

endpackage

`default_nettype wire

/* rtl/siti_cell.sv */
// ----------------------------------------------------------------------------
// Sorted id table cell
// Holds one table entry, compares it against the incoming item and, on an
// insert, keeps its entry or takes its lower neighbor's entry or the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module siti_cell #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned INDEX       = 0,
  localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 capture,
  input  logic [31:0]          cap_id,
  input  logic [7:0]           cap_rpos,
  input  logic [CW-1:0]        count,
  input  logic                 ins_en,
  input  siti_pkg::entry_t     new_entry,
  input  siti_pkg::entry_t     prev_entry,
  input  logic                 prev_ge,
  output siti_pkg::entry_t     entry,
  output siti_pkg::cell_flags_t flags
);
  import siti_pkg::*;

  logic in_use;

  assign in_use = 32'(INDEX) < 32'(count);

  always_ff @(posedge clk) begin
    if (capture) begin
      flags.ge  <= !in_use || (entry.id > cap_id);
      flags.eq  <= in_use && (entry.id == cap_id);
      flags.sel <= 32'(INDEX) == 32'(cap_rpos);
    end
    // The ge flags are monotone along the row, so the cell below the insert
    // point keeps its entry, the insert point takes the new one and the rest
    // move up by one.
    if (ins_en) begin
      if (prev_ge) begin
        entry <= prev_entry;
      end else if (flags.ge) begin
        entry <= new_entry;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/siti_gather.sv */
// ----------------------------------------------------------------------------
// Sorted id table gather logic
// Reduces the per-cell flags to an insert point, a duplicate position and
// the entry selected by a read.
// ----------------------------------------------------------------------------
`default_nettype none

module siti_gather #(
  parameter int unsigned MAX_ENTRIES = 256,
  localparam int unsigned IDXW       = $clog2(MAX_ENTRIES)
) (
  input  siti_pkg::cell_flags_t flags [MAX_ENTRIES],
  input  siti_pkg::entry_t      entries [MAX_ENTRIES],
  output logic [IDXW:0]         ins_pos,
  output logic                  dup,
  output logic [IDXW-1:0]       dup_pos,
  output siti_pkg::entry_t      rd_entry
);
  import siti_pkg::*;

  logic            any_edge;
  logic [IDXW-1:0] edge_pos;

  always_comb begin
    any_edge = 1'b0;
    edge_pos = '0;
    dup      = 1'b0;
    dup_pos  = '0;
    rd_entry = '0;
    for (int i = 0; i < int'(MAX_ENTRIES); i++) begin
      // Only one cell sees a rising ge edge, only one can match the id and
      // only one is addressed, so OR-ing the indexes encodes each one.
      if (flags[i].ge && (i == 0 || !flags[(i == 0) ? 0 : i - 1].ge)) begin
        any_edge = 1'b1;
        edge_pos = edge_pos | IDXW'(i);
      end
      if (flags[i].eq) begin
        dup     = 1'b1;
        dup_pos = dup_pos | IDXW'(i);
      end
      if (flags[i].sel) begin
        rd_entry = rd_entry | entries[i];
      end
    end
    // With every cell in use and below the new id, the insert point is one
    // past the last cell.
    ins_pos = any_edge ? {1'b0, edge_pos} : (IDXW + 1)'(MAX_ENTRIES);
  end

endmodule

`default_nettype wire

/* rtl/sorted_id_index_table_insert_top.sv */
// ----------------------------------------------------------------------------
// Sorted id index table, top level
// Table of entries kept in ascending id order in a row of shifting cells.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis_*; s_axis_tuser carries the action (insert or
// read by position). Each beat produces one result beat on m_axis_*.
// An accepted beat is compared in every cell in the same edge; in the
// evaluate step the block reduces the cell flags, forms the result and, for
// an insert, shifts the cells above the insert point up by one as the result
// is registered. No new beat is taken until the previous item has left the
// evaluate step, as the compare flags and the reduction serve one item.
// The result register lets a new beat be accepted while the previous result
// waits; if the receiver stalls, the block holds the finished item in its
// evaluate step until the result register frees and accepts nothing meanwhile.
// Reset empties the table, clears the count and sets the data end offset to
// zero. Writing start_offset over the APB port loads the data end offset
// too; the table contents stay. Write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_id_index_table_insert_top_assert.svh"

module sorted_id_index_table_insert_top #(
  parameter int unsigned MAX_ENTRIES = siti_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // tdata: elem_id[31:0], orig_size[62:32], stored_size[94:63],
  //        size_flag_word[126:95], read_pos[134:127], zero pad[135]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  // tuser: action[0]
  input  logic [0:0]   s_axis_tuser,
  // tdata: status[2:0], position[10:3], entry_id[42:11], entry_size[73:43],
  //        entry_flag_word[105:74], entry_offset[137:106],
  //        entry_count[146:138], data_end[178:147], zero pad[183:179]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import siti_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e state, state_next;

  logic [CW-1:0] count, count_next;
  logic [31:0]   end_offset, end_offset_next;
  logic [31:0]   start_offset;

  // Held item payload.
  logic        item_action;
  logic [31:0] item_id;
  logic [30:0] item_orig;
  logic [31:0] item_stored;
  logic [31:0] item_flag;
  logic [7:0]  item_rpos;

  logic accept, commit, ins_en, cfg_wr;

  entry_t      new_entry;
  entry_t      entries [MAX_ENTRIES];
  cell_flags_t flags   [MAX_ENTRIES];

  logic [IDXW:0]   ins_pos;
  logic            dup;
  logic [IDXW-1:0] dup_pos;
  entry_t          rd_entry;

  status_e     res_status;
  logic [7:0]  res_pos;
  entry_t      res_entry;
  logic        do_insert;

  logic [MAX_ENTRIES-1:0] ge_vec, eq_vec, ge_rise;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? start_offset : '0;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == S_EVAL) && (!m_axis_tvalid || m_axis_tready);
  assign ins_en        = commit && do_insert;

  assign new_entry.id        = item_id;
  assign new_entry.size      = item_orig;
  assign new_entry.flag_word = item_flag;
  assign new_entry.offset    = end_offset;

  for (genvar g = 0; g < int'(MAX_ENTRIES); g++) begin : g_cell
    siti_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .capture   (accept),
      .cap_id    (s_axis_tdata[31:0]),
      .cap_rpos  (s_axis_tdata[134:127]),
      .count     (count),
      .ins_en    (ins_en),
      .new_entry (new_entry),
      .prev_entry(entries[(g == 0) ? 0 : g - 1]),
      .prev_ge   ((g == 0) ? 1'b0 : flags[(g == 0) ? 0 : g - 1].ge),
      .entry     (entries[g]),
      .flags     (flags[g])
    );
    assign ge_vec[g] = flags[g].ge;
    assign eq_vec[g] = flags[g].eq;
  end

  assign ge_rise = ge_vec ^ {ge_vec[MAX_ENTRIES-2:0], 1'b0};

  siti_gather #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_gather (
    .flags   (flags),
    .entries (entries),
    .ins_pos (ins_pos),
    .dup     (dup),
    .dup_pos (dup_pos),
    .rd_entry(rd_entry)
  );

  always_comb begin
    res_status      = ST_INSERTED;
    res_pos         = 8'(ins_pos);
    res_entry       = '0;
    do_insert       = 1'b0;
    count_next      = count;
    end_offset_next = end_offset;
    if (item_action) begin
      res_pos = item_rpos;
      if (32'(item_rpos) < 32'(count)) begin
        res_status = ST_READ_OK;
        res_entry  = rd_entry;
      end else begin
        res_status = ST_READ_OOR;
      end
    end else if (dup) begin
      res_status = ST_DUPLICATE;
      res_pos    = 8'(dup_pos);
    end else if (item_orig == '0) begin
      res_status = ST_SKIPPED;
    end else if (32'(count) == 32'(MAX_ENTRIES)) begin
      res_status = ST_FULL;
    end else begin
      do_insert        = 1'b1;
      res_entry.offset = end_offset;
      count_next       = count + CW'(1);
      end_offset_next  = end_offset + item_stored;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      end_offset    <= '0;
      start_offset  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        start_offset <= pwdata;
        end_offset   <= pwdata;
      end else if (commit) begin
        end_offset <= end_offset_next;
      end
      if (commit) begin
        count <= count_next;
      end
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= s_axis_tuser[0];
      item_id     <= s_axis_tdata[31:0];
      item_orig   <= s_axis_tdata[62:32];
      item_stored <= s_axis_tdata[94:63];
      item_flag   <= s_axis_tdata[126:95];
      item_rpos   <= s_axis_tdata[134:127];
    end
    if (commit) begin
      m_axis_tdata <= {5'd0, end_offset_next, 9'(count_next), res_entry.offset,
                       res_entry.flag_word, res_entry.size, res_entry.id,
                       res_pos, res_status};
    end
  end

  // Ids are unique, so at most one cell can match.
  `SITI_ASSERT_SAME(a_one_match, clk, rst, state == S_EVAL, $onehot0(eq_vec))
  // The cells are sorted, so the ge flags switch on at most once along the row.
  `SITI_ASSERT_SAME(a_sorted, clk, rst, state == S_EVAL, $onehot0(ge_rise))
  `SITI_ASSERT_SAME(a_count_max, clk, rst, 1'b1, 32'(count) <= 32'(MAX_ENTRIES))
  `SITI_ASSERT_NEXT(a_count_step, clk, rst, ins_en, count == $past(count) + CW'(1))

endmodule

`default_nettype wire
